// ===== rtl/core/tptf_pkg.sv =====
// ----------------------------------------------------------------------------
// tptf_pkg: shared sizes, types and beat layout of the TLB/page-table translator
// Holds the sizing constants, the derived field widths and the structs that
// pass lookup and update information between the translator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tptf_pkg;

	// Sizing. All four counts are powers of two, so page and offset are bit fields.
	localparam int FRAME_COUNT = 128;
	localparam int TLB_ENTRIES = 16;
	localparam int PAGE_BYTES  = 256;
	localparam int PAGE_COUNT  = 256;

	localparam int ADDR_W       = 16;
	localparam int OFFSET_BITS  = $clog2(PAGE_BYTES);
	localparam int PAGE_BITS    = $clog2(PAGE_COUNT);
	localparam int FRAME_BITS   = $clog2(FRAME_COUNT);
	localparam int TLB_IDX_BITS = $clog2(TLB_ENTRIES);
	localparam int COUNT_BITS   = $clog2(FRAME_COUNT + 1);

	// Result field widths.
	localparam int PA_W     = 15;
	localparam int EVPAGE_W = 8;

	// Beat layout.
	localparam int IN_TDATA_W  = 16;
	localparam int PA_LSB      = 0;
	localparam int HIT_BIT     = PA_LSB + PA_W;
	localparam int FAULT_BIT   = HIT_BIT + 1;
	localparam int EVICT_BIT   = FAULT_BIT + 1;
	localparam int EVPAGE_LSB  = EVICT_BIT + 1;
	localparam int OUT_USED_W  = EVPAGE_LSB + EVPAGE_W;
	localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

	typedef logic [PAGE_BITS-1:0]    page_t;
	typedef logic [FRAME_BITS-1:0]   frame_t;
	typedef logic [OFFSET_BITS-1:0]  offset_t;
	typedef logic [TLB_IDX_BITS-1:0] tlb_idx_t;

	typedef struct packed {
		logic   hit;
		frame_t frame;
	} tlb_lookup_t;

	typedef struct packed {
		logic   commit;
		logic   fault;
		logic   evict;
		page_t  page;
		page_t  victim;
		frame_t frame;
	} tlb_update_t;

	typedef struct packed {
		logic   table_hit;
		logic   fault;
		logic   evict;
		page_t  victim;
		frame_t frame;
	} pt_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/tptf_page_table.sv =====
// ----------------------------------------------------------------------------
// tptf_page_table: page-table frame memory, valid bits and FIFO of residents
// Reads the frame memory, the queue head and the page's valid bit in the accept
// cycle, then decides hit, fault and eviction and writes back on commit.
// ----------------------------------------------------------------------------
`default_nettype none

module tptf_page_table import tptf_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       rd_en,
	input  wire page_t      rd_page,
	input  wire page_t      page_s1,
	input  wire logic       tlb_hit,
	input  wire logic       commit,
	output pt_status_t      status
);

	frame_t table_frame_mem [PAGE_COUNT];
	page_t  queue_mem [FRAME_COUNT];

	logic [PAGE_COUNT-1:0] table_valid_q;
	frame_t                head_q;
	logic [COUNT_BITS-1:0] count_q;
	frame_t                frame_rd_s1;
	page_t                 victim_rd_s1;
	logic                  valid_rd_s1;

	logic                  full;
	logic                  wr_en;
	frame_t                new_frame;
	logic [PAGE_COUNT-1:0] table_valid_d;

	// Frames are handed out in order and a reused frame always goes back to the
	// queue slot it came from, so a page's frame equals its queue slot.
	always_comb begin
		full             = (count_q == COUNT_BITS'(FRAME_COUNT));
		new_frame        = full ? head_q : FRAME_BITS'(count_q);
		status.table_hit = valid_rd_s1;
		status.fault     = !tlb_hit && !status.table_hit;
		status.evict     = status.fault && full;
		status.victim    = victim_rd_s1;
		status.frame     = status.table_hit ? frame_rd_s1 : new_frame;
		wr_en            = commit && status.fault;
		table_valid_d    = table_valid_q;
		if (status.evict) begin
			table_valid_d[victim_rd_s1] = 1'b0;
		end
		table_valid_d[page_s1] = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			frame_rd_s1  <= table_frame_mem[rd_page];
			victim_rd_s1 <= queue_mem[head_q];
			valid_rd_s1  <= table_valid_q[rd_page];
		end
		if (wr_en) begin
			table_frame_mem[page_s1] <= new_frame;
			queue_mem[new_frame]     <= page_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_valid_q <= '0;
			head_q        <= '0;
			count_q       <= '0;
		end else if (wr_en) begin
			table_valid_q <= table_valid_d;
			if (status.evict) begin
				head_q <= (head_q == FRAME_BITS'(FRAME_COUNT - 1)) ? '0 : head_q + 1'b1;
			end else begin
				count_q <= count_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/tptf_tlb.sv =====
// ----------------------------------------------------------------------------
// tptf_tlb: fully associative translation buffer with victim invalidation
// Looks a page up across all entries, invalidates entries of an evicted
// page and fills the first empty slot, or the round-robin slot when full.
// ----------------------------------------------------------------------------
`default_nettype none

module tptf_tlb import tptf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire page_t       page_s1,
	input  wire tlb_update_t upd,
	output tlb_lookup_t      lookup
);

	logic [TLB_ENTRIES-1:0] valid_q;
	page_t                  tag_q [TLB_ENTRIES];
	frame_t                 frame_q [TLB_ENTRIES];
	tlb_idx_t               ctr_q;

	logic [TLB_ENTRIES-1:0] valid_kept;
	logic [TLB_ENTRIES-1:0] valid_next;
	tlb_idx_t               hit_idx;
	tlb_idx_t               empty_idx;
	logic                   any_empty;
	tlb_idx_t               slot;

	// Lowest matching entry wins; entries of the evicted page drop out before
	// the empty-slot search.
	always_comb begin
		lookup.hit = 1'b0;
		hit_idx    = '0;
		any_empty  = 1'b0;
		empty_idx  = '0;
		for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
			valid_kept[i] = valid_q[i] && !(upd.evict && tag_q[i] == upd.victim);
			if (valid_q[i] && tag_q[i] == page_s1) begin
				lookup.hit = 1'b1;
				hit_idx    = TLB_IDX_BITS'(i);
			end
			if (!valid_kept[i]) begin
				any_empty = 1'b1;
				empty_idx = TLB_IDX_BITS'(i);
			end
		end
		lookup.frame     = frame_q[hit_idx];
		slot             = any_empty ? empty_idx : ctr_q;
		valid_next       = valid_kept;
		valid_next[slot] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ctr_q   <= '0;
		end else if (upd.commit && upd.fault) begin
			valid_q <= valid_next;
			if (!any_empty) begin
				ctr_q <= (ctr_q == TLB_IDX_BITS'(TLB_ENTRIES - 1)) ? '0 : ctr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.commit && upd.fault) begin
			tag_q[slot]   <= upd.page;
			frame_q[slot] <= upd.frame;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/tlb_page_table_fifo_translator_core.sv =====
// ----------------------------------------------------------------------------
// tlb_page_table_fifo_translator_core: virtual to physical address translator
// TLB in front of a page table, with in-order frame allocation and FIFO
// replacement of resident pages on a page fault.
// ----------------------------------------------------------------------------
// Each input beat carries a 16-bit logical address (page in bits 15:8, offset
// in bits 7:0) and produces exactly one output beat with the 15-bit physical
// address, the TLB-hit and page-fault flags, an eviction flag and the evicted
// page number (zero when nothing was evicted). In the accept cycle the
// page-table frame memory, the FIFO head and the page's valid bit are read and
// registered; then, once the output register is free, the TLB is searched, the
// outcome is decided and the memories, valid bits and TLB are written back
// together with the output register. The next address is taken only after
// that write-back, so no access ever sees stale memory data, and the block
// never holds more than one address in flight. A finished result waits
// in the output register while the next address is already accepted; the
// second stage holds only when the output register is still occupied. All
// valid bits live in flip-flops cleared by reset, so there is no clearing
// pass and the block is ready right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tlb_page_table_fifo_translator_core import tptf_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Address input. tdata: vaddr[15:0].
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// Translation result. tdata: physical_address[14:0], tlb_hit[15],
	// pg_fault[16], did_evict[17], evicted_page[25:18], zero[31:26].
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata
);

	logic    busy_s1;
	page_t   page_s1;
	offset_t offset_s1;

	logic    accept;
	logic    out_free;
	logic    commit;
	page_t   in_page;

	tlb_lookup_t tlb_lookup;
	tlb_update_t tlb_upd;
	pt_status_t  pt_status;

	frame_t                 frame;
	logic [PA_W-1:0]        phys_addr;
	logic [EVPAGE_W-1:0]    ev_page;

	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	// One address in flight; stage two completes when the output register is free.
	assign out_free = !m_tvalid_q || m_tready;
	assign commit   = busy_s1 && out_free;
	assign s_tready = !busy_s1;
	assign accept   = s_tvalid && s_tready;
	assign in_page  = PAGE_BITS'(s_tdata >> OFFSET_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (accept) begin
			busy_s1 <= 1'b1;
		end else if (commit) begin
			busy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_s1   <= in_page;
			offset_s1 <= OFFSET_BITS'(s_tdata);
		end
	end

	tptf_page_table u_page_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_page (in_page),
		.page_s1 (page_s1),
		.tlb_hit (tlb_lookup.hit),
		.commit  (commit),
		.status  (pt_status)
	);

	always_comb begin
		tlb_upd.commit = commit;
		tlb_upd.fault  = pt_status.fault;
		tlb_upd.evict  = pt_status.evict;
		tlb_upd.page   = page_s1;
		tlb_upd.victim = pt_status.victim;
		tlb_upd.frame  = pt_status.frame;
	end

	tptf_tlb u_tlb (
		.clk     (clk),
		.arst_n  (arst_n),
		.page_s1 (page_s1),
		.upd     (tlb_upd),
		.lookup  (tlb_lookup)
	);

	// The TLB answer has priority; otherwise the page table or the new frame.
	always_comb begin
		frame     = tlb_lookup.hit ? tlb_lookup.frame : pt_status.frame;
		phys_addr = PA_W'({frame, offset_s1});
		ev_page   = pt_status.evict ? EVPAGE_W'(pt_status.victim) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			m_tdata_q <= {{OUT_PAD_W{1'b0}}, ev_page, pt_status.evict, pt_status.fault,
				tlb_lookup.hit, phys_addr};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/tptf_checker.sv =====
// ----------------------------------------------------------------------------
// tptf_checker: port-level checks for the translator
// Watches the stream ports of the top level and flags result beats or
// handshake sequences that the translator can never legally produce.
// ----------------------------------------------------------------------------
`default_nettype none

module tptf_checker import tptf_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_tvalid,
	input wire logic                   s_tready,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [OUT_TDATA_W-1:0] m_tdata
);

	// An accepted address occupies the block, so s_tready drops after an accept.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("address accepted while the previous one was in flight");

	// A stalled result stays put.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// A translation is either a TLB hit or a fault or neither, never both.
	a_hit_excludes_fault: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[HIT_BIT] && m_tdata[FAULT_BIT]))
		else $error("TLB hit reported together with a page fault");

	// Eviction only on a fault; no eviction means a zero page number.
	a_evict_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[EVICT_BIT] ? m_tdata[FAULT_BIT]
			: (m_tdata[EVPAGE_LSB +: EVPAGE_W] == '0)))
		else $error("eviction fields inconsistent with the fault flag");

endmodule

bind tlb_page_table_fifo_translator_core tptf_checker u_tptf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
